### src/stepper_trapezoid_profile_generator_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the trapezoid profile generator
// ----------------------------------------------------------------------------
`ifndef STEPPER_TRAPEZOID_PROFILE_GENERATOR_MACROS_SVH
`define STEPPER_TRAPEZOID_PROFILE_GENERATOR_MACROS_SVH

// condition must hold at every edge out of reset
`define STPG_ASSERT_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("stpg assertion failed");

// antecedent at one edge implies consequent at the next
`define STPG_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("stpg assertion failed");

`endif

### src/stpg_pkg.sv
// ----------------------------------------------------------------------------
// stpg_pkg
// Shared widths, codes and defaults of the trapezoid profile generator.
// ----------------------------------------------------------------------------
package stpg_pkg;

    localparam int STEPS_W        = 24;
    localparam int SPD_W          = 20;
    localparam int IPS_W          = 11;
    localparam int STAT_W         = 3;
    localparam int CFG_IDX_W      = 3;
    localparam int NUM_W          = 26;  // dividend width of the shared divider
    localparam int RAMP_DEPTH_DEF = 31;

    localparam logic [CFG_IDX_W-1:0] CFG_ACCEL = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IPS   = 3'd3;

    typedef enum logic [STAT_W-1:0] {
        ST_OK          = 3'd0,
        ST_STEPS_LOW   = 3'd1,
        ST_ACCEL_LOW   = 3'd2,
        ST_MAX_LOW     = 3'd3,
        ST_MAX_LT_ACC  = 3'd4,
        ST_MIN_LOW     = 3'd5,
        ST_MIN_GT_MAX  = 3'd6
    } t_status;

    typedef struct packed {
        logic                 go;
        logic [NUM_W-1:0]     num;
        logic [IPS_W-1:0]     den;
    } t_div_req;

endpackage

### src/stpg_div.sv
// ----------------------------------------------------------------------------
// stpg_div
// Restoring divider, one quotient bit per cycle, shared by all divisions.
// ----------------------------------------------------------------------------
module stpg_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  stpg_pkg::t_div_req            i_req,
    output logic                          o_done,
    output logic [stpg_pkg::NUM_W-1:0]    o_quo
);
    import stpg_pkg::*;

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [IPS_W-1:0] r_rem, n_rem;
    logic [IPS_W-1:0] r_den;
    logic [NUM_W-1:0] r_q, n_q;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [IPS_W:0]   w_sh;
    logic [IPS_W:0]   w_diff;

    always_comb begin
        w_sh   = {r_rem, r_q[NUM_W-1]};
        w_diff = w_sh - {1'b0, r_den};
        if (w_sh >= {1'b0, r_den}) begin
            n_rem = w_diff[IPS_W-1:0];
            n_q   = {r_q[NUM_W-2:0], 1'b1};
        end else begin
            n_rem = w_sh[IPS_W-1:0];
            n_q   = {r_q[NUM_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.go && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.go && !r_busy) begin
            r_q   <= i_req.num;
            r_den <= i_req.den;
            r_rem <= '0;
        end else if (r_busy) begin
            r_q   <= n_q;
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_q;

endmodule

### src/stepper_trapezoid_profile_generator.sv
// ----------------------------------------------------------------------------
// stepper_trapezoid_profile_generator
// Trapezoid move planner: per-interval setup, ramp build, then run segment
// followed by the ramp words in reverse, or a single status word on a bad move.
//
//   channel  | handshake              | payload
//   ---------+------------------------+-----------------------------------
//   in       | i_in_valid/o_in_ready  | i_total_steps
//   out      | o_out_valid/i_out_ready| o_segment_steps, o_segment_speed_sps,
//            |                        | o_last_segment, o_status
//   cfg      | i_cfg_valid/o_cfg_ready| i_cfg_index, i_cfg_data
//
// Setup is four divisions, each ramp entry one more, all on one radix-2
// divider; once the ramp is built the words follow, one word per cycle
// while the sink is ready.
// Synchronous active-low reset; the ramp store needs no clearing.
// The input stays not ready until the last word of a move is loaded.
// ----------------------------------------------------------------------------
module stepper_trapezoid_profile_generator #(
    parameter int RAMP_DEPTH = stpg_pkg::RAMP_DEPTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [stpg_pkg::STEPS_W-1:0]      i_total_steps,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [stpg_pkg::STEPS_W-1:0]      o_segment_steps,
    output logic [stpg_pkg::SPD_W-1:0]        o_segment_speed_sps,
    output logic                              o_last_segment,
    output logic [stpg_pkg::STAT_W-1:0]       o_status,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [stpg_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [stpg_pkg::SPD_W-1:0]        i_cfg_data
);
    import stpg_pkg::*;

    `include "stepper_trapezoid_profile_generator_macros.svh"

    localparam int CNT_W = $clog2(RAMP_DEPTH + 1);
    localparam int AW    = (RAMP_DEPTH > 1) ? $clog2(RAMP_DEPTH) : 1;

    typedef enum logic [9:0] {
        S_IDLE = 10'b0000000001,
        S_DACC = 10'b0000000010,
        S_DMAX = 10'b0000000100,
        S_DMIN = 10'b0000001000,
        S_DBUD = 10'b0000010000,
        S_RAMP = 10'b0000100000,
        S_DST  = 10'b0001000000,
        S_RUN  = 10'b0010000000,
        S_DEC  = 10'b0100000000,
        S_ERR  = 10'b1000000000
    } t_state;

    t_state r_state;

    logic [SPD_W-1:0]   r_accel, r_min, r_max;
    logic [IPS_W-1:0]   r_ips_reg;
    logic [IPS_W-1:0]   w_ips;

    logic [STEPS_W-1:0] r_total;
    logic [SPD_W-1:0]   r_acc, r_maxspp, r_minspp, r_speed, r_last_spd;
    logic [STEPS_W-1:0] r_budget, r_pos;
    logic [CNT_W-1:0]   r_cnt, r_idx;
    t_status            r_err;

    logic [STEPS_W-1:0] r_ramp_steps [RAMP_DEPTH];
    logic [SPD_W-1:0]   r_ramp_speed [RAMP_DEPTH];

    t_div_req           r_div;
    logic               w_div_done;
    logic [NUM_W-1:0]   w_quo;
    logic [SPD_W-1:0]   w_quo1;

    logic               r_out_valid;
    logic [STEPS_W-1:0] r_seg_steps;
    logic [SPD_W-1:0]   r_seg_spd;
    logic               r_seg_last;
    t_status            r_seg_stat;
    logic               w_slot;
    logic               w_load;
    logic               w_ramp_more;
    logic               w_div_go;

    t_status            w_stat;
    logic [SPD_W:0]     w_spd_sum;
    logic [SPD_W-1:0]   w_spd_next;
    logic [STEPS_W-1:0] w_st;
    logic [NUM_W-1:0]   w_reach;
    logic [30:0]        w_prod;
    logic [SPD_W:0]     w_run_sum;
    logic [SPD_W-1:0]   w_run_spd;
    logic [STEPS_W:0]   w_pos2;
    logic [AW-1:0]      w_rd_addr;

    stpg_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (r_div),
        .o_done  (w_div_done),
        .o_quo   (w_quo)
    );

    assign w_ips  = (r_ips_reg == '0) ? IPS_W'(1) : r_ips_reg;
    assign w_quo1 = (w_quo == '0) ? SPD_W'(1) : w_quo[SPD_W-1:0];
    assign w_slot = !r_out_valid || i_out_ready;
    assign w_load = w_slot && (r_state == S_RUN || r_state == S_DEC || r_state == S_ERR);

    assign w_ramp_more = (r_pos < r_budget) && (r_cnt < CNT_W'(RAMP_DEPTH))
                         && (w_spd_next < r_maxspp);

    // one request pulse per division
    assign w_div_go = (r_state == S_IDLE && i_in_valid && w_stat == ST_OK)
                      || ((r_state == S_DACC || r_state == S_DMAX || r_state == S_DMIN)
                          && w_div_done)
                      || (r_state == S_RAMP && w_ramp_more);

    always_comb begin
        if (i_total_steps == '0)     w_stat = ST_STEPS_LOW;
        else if (r_accel == '0)      w_stat = ST_ACCEL_LOW;
        else if (r_max == '0)        w_stat = ST_MAX_LOW;
        else if (r_max < r_accel)    w_stat = ST_MAX_LT_ACC;
        else if (r_min == '0)        w_stat = ST_MIN_LOW;
        else if (r_min > r_max)      w_stat = ST_MIN_GT_MAX;
        else                         w_stat = ST_OK;
    end

    always_comb begin
        w_spd_sum  = {1'b0, r_speed} + {1'b0, r_acc};
        if (r_cnt == '0)
            w_spd_next = r_minspp;
        else if (w_spd_sum > {1'b0, r_maxspp})
            w_spd_next = r_maxspp;
        else
            w_spd_next = w_spd_sum[SPD_W-1:0];
        w_st      = (w_quo == '0) ? STEPS_W'(1) : w_quo[STEPS_W-1:0];
        w_reach   = NUM_W'(r_pos) + NUM_W'(w_st) + NUM_W'(r_acc);
        w_prod    = 31'(r_speed) * 31'(w_ips);
        w_run_sum = {1'b0, r_last_spd} + {1'b0, r_accel};
        if (r_cnt == '0)
            w_run_spd = r_accel;
        else if (w_run_sum < {1'b0, r_max})
            w_run_spd = w_run_sum[SPD_W-1:0];
        else
            w_run_spd = r_max;
        w_pos2    = {r_pos, 1'b0};
        w_rd_addr = AW'(r_idx - 1'b1);
    end

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accel   <= SPD_W'(100);
            r_min     <= SPD_W'(100);
            r_max     <= SPD_W'(1000);
            r_ips_reg <= IPS_W'(10);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_ACCEL: r_accel   <= i_cfg_data;
                CFG_MIN:   r_min     <= i_cfg_data;
                CFG_MAX:   r_max     <= i_cfg_data;
                CFG_IPS:   r_ips_reg <= i_cfg_data[IPS_W-1:0];
                default:   ;
            endcase
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_div.go    <= 1'b0;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
            r_idx       <= '0;
        end else begin
            r_div.go <= w_div_go;
            if (w_load) r_out_valid <= 1'b1;
            else if (i_out_ready) r_out_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_total <= i_total_steps;
                        r_err   <= w_stat;
                        r_cnt   <= '0;
                        if (w_stat != ST_OK) begin
                            r_state <= S_ERR;
                        end else begin
                            r_div.num <= NUM_W'(r_accel);
                            r_div.den <= w_ips;
                            r_state   <= S_DACC;
                        end
                    end
                end
                S_DACC: if (w_div_done) begin
                    r_acc     <= w_quo1;
                    r_div.num <= NUM_W'(r_max);
                    r_state   <= S_DMAX;
                end
                S_DMAX: if (w_div_done) begin
                    r_maxspp  <= w_quo1;
                    r_div.num <= NUM_W'(r_min);
                    r_state   <= S_DMIN;
                end
                S_DMIN: if (w_div_done) begin
                    r_minspp  <= w_quo1;
                    r_div.num <= {1'b0, r_total, 1'b0};
                    r_div.den <= IPS_W'(5);
                    r_state   <= S_DBUD;
                end
                S_DBUD: if (w_div_done) begin
                    r_budget <= w_quo[STEPS_W-1:0];
                    r_pos    <= '0;
                    r_state  <= S_RAMP;
                end
                S_RAMP: begin
                    if (w_ramp_more) begin
                        r_speed   <= w_spd_next;
                        r_div.num <= NUM_W'(w_spd_next);
                        r_div.den <= w_ips;
                        r_state   <= S_DST;
                    end else begin
                        r_state <= S_RUN;
                    end
                end
                S_DST: if (w_div_done) begin
                    if (w_reach > NUM_W'(r_budget)) begin
                        r_state <= S_RUN;
                    end else begin
                        r_pos      <= r_pos + w_st;
                        r_last_spd <= w_prod[SPD_W-1:0];
                        r_cnt      <= r_cnt + 1'b1;
                        r_state    <= S_RAMP;
                    end
                end
                S_RUN: if (w_slot) begin
                    r_seg_steps <= r_total - w_pos2[STEPS_W-1:0];
                    r_seg_spd   <= w_run_spd;
                    r_seg_last  <= (r_cnt == '0);
                    r_seg_stat  <= ST_OK;
                    r_idx       <= r_cnt;
                    r_state     <= (r_cnt == '0) ? S_IDLE : S_DEC;
                end
                S_DEC: if (w_slot) begin
                    r_seg_steps <= r_ramp_steps[w_rd_addr];
                    r_seg_spd   <= r_ramp_speed[w_rd_addr];
                    r_seg_last  <= (r_idx == CNT_W'(1));
                    r_seg_stat  <= ST_OK;
                    r_idx       <= r_idx - 1'b1;
                    if (r_idx == CNT_W'(1)) r_state <= S_IDLE;
                end
                S_ERR: if (w_slot) begin
                    r_seg_steps <= '0;
                    r_seg_spd   <= '0;
                    r_seg_last  <= 1'b1;
                    r_seg_stat  <= r_err;
                    r_state     <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // ramp store write
    always_ff @(posedge i_clk) begin
        if (r_state == S_DST && w_div_done && !(w_reach > NUM_W'(r_budget))) begin
            r_ramp_steps[AW'(r_cnt)] <= w_st;
            r_ramp_speed[AW'(r_cnt)] <= w_prod[SPD_W-1:0];
        end
    end

    assign o_in_ready          = (r_state == S_IDLE);
    assign o_cfg_ready         = 1'b1;
    assign o_out_valid         = r_out_valid;
    assign o_segment_steps     = r_seg_steps;
    assign o_segment_speed_sps = r_seg_spd;
    assign o_last_segment      = r_seg_last;
    assign o_status            = r_seg_stat;

    `STPG_ASSERT_ALWAYS(a_cnt_range, r_cnt <= CNT_W'(RAMP_DEPTH))
    `STPG_ASSERT_ALWAYS(a_err_is_last, !r_out_valid || r_seg_stat == ST_OK || r_seg_last)
    `STPG_ASSERT_NEXT(a_accept_busy, i_in_valid && o_in_ready, !o_in_ready)
    `STPG_ASSERT_ALWAYS(a_dec_idx, r_state != S_DEC || r_idx != '0)

endmodule
